### rtl/metp_pkg.sv
package metp_pkg;

  localparam int COLUMNS_DEF   = 1024;
  localparam int ROWS_DEF      = 1024;
  localparam int FRAC_BITS_DEF = 44;

  // Integer bits above the fraction in the working word (52 bits at 44 fraction bits).
  localparam int GUARD_BITS = 8;

  localparam int PIX_W      = 10;
  localparam int CFG_W      = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int ZOOM_W     = 7;
  localparam int ITER_W     = 16;
  localparam int SHADE_W    = 8;
  localparam int DIVIDEND_W = ITER_W + SHADE_W;

  localparam int ZOOM_MIN = -2;
  localparam int ZOOM_MAX = 32;

  localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_RE  = 2'd0,
    REG_CENTER_IM  = 2'd1,
    REG_ZOOM_LEVEL = 2'd2,
    REG_MAX_ITER   = 2'd3
  } reg_idx_e;

  typedef enum logic [6:0] {
    S_IDLE = 7'b000_0001,
    S_TEST = 7'b000_0010,
    S_SR   = 7'b000_0100,
    S_SI   = 7'b000_1000,
    S_P    = 7'b001_0000,
    S_DIV  = 7'b010_0000,
    S_DONE = 7'b100_0000
  } state_e;

endpackage

### rtl/metp_mul.sv
module metp_mul #(
  parameter int  FRAC_BITS = metp_pkg::FRAC_BITS_DEF,
  localparam int OPW       = FRAC_BITS + 1,
  localparam int RW        = FRAC_BITS + 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [OPW-1:0] a_i,
  input  logic [OPW-1:0] b_i,
  output logic           done_o,
  output logic [RW-1:0]  res_o
);

  localparam int HW   = (OPW + 1) / 2;
  localparam int PPW  = OPW + HW;
  localparam int ACCW = 2 * OPW;

  logic [3:0]      ph_q;
  logic [OPW-1:0]  a_q, b_q;
  logic [PPW-1:0]  pp_q;
  logic [ACCW-1:0] acc_q;
  logic [HW-1:0]   b_hi;

  assign b_hi = HW'(b_q[OPW-1:HW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= '0;
    end else begin
      ph_q <= {ph_q[2:0], start_i};
    end
  end

  // Low digit of b, then high digit, then fold the high partial product in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (ph_q[0]) begin
      pp_q <= PPW'(a_q) * PPW'(b_q[HW-1:0]);
    end else if (ph_q[1]) begin
      acc_q <= ACCW'(pp_q);
      pp_q  <= PPW'(a_q) * PPW'(b_hi);
    end else if (ph_q[2]) begin
      acc_q <= acc_q + (ACCW'(pp_q) << HW);
    end
  end

  assign done_o = ph_q[3];
  assign res_o  = acc_q[FRAC_BITS +: RW];

endmodule

### rtl/metp_div.sv
module metp_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [metp_pkg::DIVIDEND_W-1:0]     dividend_i,
  input  logic [metp_pkg::ITER_W-1:0]         divisor_i,
  output logic                                done_o,
  output logic [metp_pkg::SHADE_W-1:0]        quot_o
);

  localparam int DW    = metp_pkg::DIVIDEND_W;
  localparam int SW    = metp_pkg::SHADE_W;
  localparam int DSR_W = metp_pkg::ITER_W + SW - 1;
  localparam int CW    = $clog2(SW);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DW-1:0]    rem_q;
  logic [DSR_W-1:0] dsr_q;
  logic [SW-1:0]    quot_q;
  logic             ge;

  assign ge = rem_q >= DW'(dsr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(SW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restoring division, one quotient bit a cycle, most significant first.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsr_q  <= DSR_W'(divisor_i) << (SW - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - DW'(dsr_q);
      end
      quot_q <= {quot_q[SW-2:0], ge};
      dsr_q  <= dsr_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### rtl/mandelbrot_escape_time_pixel_core.sv
// Escape-time evaluator for one Mandelbrot pixel per request. A request gives a
// column and row; the point c is the configured center plus the pixel offset
// times 2/(COLUMNS*2^zoom), then z = z*z + c is iterated from zero in signed
// fixed point until |z|^2 reaches 4 or the count passes max_iterations. Each
// iteration is one test state plus three products on the single shared
// multiplier, which works the full magnitude against one half-width digit at a
// time. A request that escapes, by |z|^2 or by one part of z alone reaching 2,
// then runs the shade divider; one whose limit runs out does not.
// Input is stalled while a pixel is in flight; the result register lets the
// next request enter while a finished result still waits downstream.
// Configuration must only be written while no pixel is in flight.
module mandelbrot_escape_time_pixel_core #(
  parameter int COLUMNS   = metp_pkg::COLUMNS_DEF,
  parameter int ROWS      = metp_pkg::ROWS_DEF,
  parameter int FRAC_BITS = metp_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [metp_pkg::PIX_W-1:0]       pixel_col_i,
  input  logic [metp_pkg::PIX_W-1:0]       pixel_row_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [metp_pkg::SHADE_W-1:0]     shade_o,
  output logic                             escaped_o,
  input  logic                             cfg_we_i,
  input  logic [metp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [metp_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int IW     = FRAC_BITS + metp_pkg::GUARD_BITS;
  localparam int OPW    = FRAC_BITS + 1;
  localparam int RW     = FRAC_BITS + 2;
  localparam int NW     = metp_pkg::ITER_W + 1;
  localparam int CW     = metp_pkg::CFG_W;
  localparam int ZW     = metp_pkg::ZOOM_W;
  localparam int SW     = metp_pkg::SHADE_W;
  localparam int DVW    = metp_pkg::DIVIDEND_W;
  localparam int SH_W   = 8;
  localparam int LOG_D  = ($clog2(COLUMNS) > $clog2(ROWS)) ? $clog2(COLUMNS) : $clog2(ROWS);
  localparam int OFFW   = ((LOG_D > metp_pkg::PIX_W) ? LOG_D : metp_pkg::PIX_W) + 2;

  localparam logic signed [SH_W-1:0] SHIFT_BASE = SH_W'(FRAC_BITS + 1 - $clog2(COLUMNS));
  localparam logic signed [ZW-1:0]   ZMIN       = ZW'(metp_pkg::ZOOM_MIN);
  localparam logic signed [ZW-1:0]   ZMAX       = ZW'(metp_pkg::ZOOM_MAX);
  localparam logic signed [IW-1:0]   TWO_FX     = IW'(1) << (FRAC_BITS + 1);
  localparam logic [RW:0]            FOUR_FX    = (RW + 1)'(1) << (FRAC_BITS + 2);
  localparam logic [CW-1:0]          CRE_RST    = CW'(0) - (CW'(1) << (FRAC_BITS - 1));

  metp_pkg::state_e state_q, state_d;

  logic signed [CW-1:0]   center_re_q, center_im_q;
  logic signed [ZW-1:0]   zoom_q;
  logic [metp_pkg::ITER_W-1:0] max_iter_q;

  logic signed [IW-1:0] cr_q, cr_d, ci_q, ci_d, zr_q, zr_d, zi_q, zi_d;
  logic [NW-1:0]        n_q, n_d;
  logic [OPW-1:0]       ar_q, ar_d, ai_q, ai_d;
  logic                 neg_q, neg_d;
  logic [RW-1:0]        sr_q, sr_d, si_q, si_d;
  logic [SW-1:0]        res_shade_q, res_shade_d;
  logic                 res_esc_q, res_esc_d;
  logic                 out_valid_q;
  logic [SW-1:0]        shade_q;
  logic                 escaped_q;
  logic                 out_load;

  logic signed [ZW-1:0]   zsat;
  logic signed [SH_W-1:0] shift_s;
  logic signed [OFFW-1:0] off_col, off_row;
  logic signed [IW-1:0]   cr_map, ci_map;
  logic signed [IW-1:0]   zr_abs, zi_abs, p2;
  logic [OPW-1:0]         ar_c, ai_c;
  logic                   z_big;
  logic [RW:0]            sq_sum;
  logic [DVW-1:0]         dividend;

  logic           mul_start, mul_done;
  logic [OPW-1:0] mul_a, mul_b;
  logic [RW-1:0]  mul_res;
  logic           div_start, div_done;
  logic [SW-1:0]  div_quot;

  function automatic logic signed [IW-1:0] scale_off(logic signed [OFFW-1:0] off,
                                                     logic signed [SH_W-1:0] sh);
    logic signed [IW-1:0] x;
    logic [SH_W-1:0]      nsh;
    x   = IW'(off);
    nsh = -sh;
    if (!sh[SH_W-1]) begin
      return x <<< sh[SH_W-2:0];
    end
    return x >>> nsh[SH_W-2:0];
  endfunction

  // Pixel to complex point.
  always_comb begin
    if (zoom_q < ZMIN) begin
      zsat = ZMIN;
    end else if (zoom_q > ZMAX) begin
      zsat = ZMAX;
    end else begin
      zsat = zoom_q;
    end
  end

  assign shift_s = SHIFT_BASE - SH_W'(zsat);
  assign off_col = OFFW'(pixel_col_i) - OFFW'(COLUMNS / 2);
  assign off_row = OFFW'(pixel_row_i) - OFFW'(ROWS / 2);
  assign cr_map  = IW'(center_re_q) + scale_off(off_col, shift_s);
  assign ci_map  = IW'(center_im_q) + scale_off(off_row, shift_s);

  assign zr_abs = zr_q[IW-1] ? -zr_q : zr_q;
  assign zi_abs = zi_q[IW-1] ? -zi_q : zi_q;
  assign ar_c   = zr_abs[OPW-1:0];
  assign ai_c   = zi_abs[OPW-1:0];
  assign z_big  = (zr_q >= TWO_FX) || (zr_q <= -TWO_FX) ||
                  (zi_q >= TWO_FX) || (zi_q <= -TWO_FX);
  assign sq_sum = (RW + 1)'(sr_q) + (RW + 1)'(mul_res);
  assign p2     = IW'(mul_res) << 1;
  // 255*n as n*256 - n.
  assign dividend = {n_q[metp_pkg::ITER_W-1:0], SW'(0)} - DVW'(n_q[metp_pkg::ITER_W-1:0]);

  assign in_stall_o = (state_q != metp_pkg::S_IDLE);

  always_comb begin
    state_d     = state_q;
    cr_d        = cr_q;
    ci_d        = ci_q;
    zr_d        = zr_q;
    zi_d        = zi_q;
    n_d         = n_q;
    ar_d        = ar_q;
    ai_d        = ai_q;
    neg_d       = neg_q;
    sr_d        = sr_q;
    si_d        = si_q;
    res_shade_d = res_shade_q;
    res_esc_d   = res_esc_q;
    mul_start   = 1'b0;
    mul_a       = ar_q;
    mul_b       = ai_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      metp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cr_d    = cr_map;
          ci_d    = ci_map;
          zr_d    = '0;
          zi_d    = '0;
          n_d     = '0;
          state_d = metp_pkg::S_TEST;
        end
      end
      metp_pkg::S_TEST: begin
        if (n_q > NW'(max_iter_q)) begin
          res_shade_d = '0;
          res_esc_d   = 1'b0;
          state_d     = metp_pkg::S_DONE;
        end else if (z_big) begin
          if (max_iter_q != '0) begin
            div_start = 1'b1;
            state_d   = metp_pkg::S_DIV;
          end else begin
            res_shade_d = '0;
            res_esc_d   = 1'b0;
            state_d     = metp_pkg::S_DONE;
          end
        end else begin
          ar_d      = ar_c;
          ai_d      = ai_c;
          neg_d     = zr_q[IW-1] ^ zi_q[IW-1];
          mul_start = 1'b1;
          mul_a     = ar_c;
          mul_b     = ar_c;
          state_d   = metp_pkg::S_SR;
        end
      end
      metp_pkg::S_SR: begin
        if (mul_done) begin
          sr_d      = mul_res;
          mul_start = 1'b1;
          mul_a     = ai_q;
          mul_b     = ai_q;
          state_d   = metp_pkg::S_SI;
        end
      end
      metp_pkg::S_SI: begin
        if (mul_done) begin
          if (sq_sum >= FOUR_FX) begin
            if (max_iter_q != '0) begin
              div_start = 1'b1;
              state_d   = metp_pkg::S_DIV;
            end else begin
              res_shade_d = '0;
              res_esc_d   = 1'b0;
              state_d     = metp_pkg::S_DONE;
            end
          end else begin
            si_d      = mul_res;
            mul_start = 1'b1;
            mul_a     = ar_q;
            mul_b     = ai_q;
            state_d   = metp_pkg::S_P;
          end
        end
      end
      metp_pkg::S_P: begin
        if (mul_done) begin
          zr_d    = IW'(sr_q) - IW'(si_q) + cr_q;
          zi_d    = neg_q ? (ci_q - p2) : (ci_q + p2);
          n_d     = n_q + 1'b1;
          state_d = metp_pkg::S_TEST;
        end
      end
      metp_pkg::S_DIV: begin
        if (div_done) begin
          res_shade_d = div_quot;
          res_esc_d   = 1'b1;
          state_d     = metp_pkg::S_DONE;
        end
      end
      metp_pkg::S_DONE: begin
        // hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = metp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = metp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= metp_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      center_re_q <= CRE_RST;
      center_im_q <= '0;
      zoom_q      <= '0;
      max_iter_q  <= metp_pkg::MAX_ITER_RST;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (metp_pkg::reg_idx_e'(cfg_idx_i))
          metp_pkg::REG_CENTER_RE:  center_re_q <= cfg_data_i;
          metp_pkg::REG_CENTER_IM:  center_im_q <= cfg_data_i;
          metp_pkg::REG_ZOOM_LEVEL: zoom_q      <= cfg_data_i[ZW-1:0];
          metp_pkg::REG_MAX_ITER:   max_iter_q  <= cfg_data_i[metp_pkg::ITER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cr_q        <= cr_d;
    ci_q        <= ci_d;
    zr_q        <= zr_d;
    zi_q        <= zi_d;
    n_q         <= n_d;
    ar_q        <= ar_d;
    ai_q        <= ai_d;
    neg_q       <= neg_d;
    sr_q        <= sr_d;
    si_q        <= si_d;
    res_shade_q <= res_shade_d;
    res_esc_q   <= res_esc_d;
    if (out_load) begin
      shade_q   <= res_shade_q;
      escaped_q <= res_esc_q;
    end
  end

  metp_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  metp_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dividend),
    .divisor_i (max_iter_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign shade_o     = shade_q;
  assign escaped_o   = escaped_q;

endmodule

### tb/sv/tb.sv
module tb;

  localparam int COLUMNS   = metp_pkg::COLUMNS_DEF;
  localparam int ROWS      = metp_pkg::ROWS_DEF;
  localparam int FRAC_BITS = metp_pkg::FRAC_BITS_DEF;
  localparam int PIX_W     = metp_pkg::PIX_W;
  localparam int SHADE_W   = metp_pkg::SHADE_W;
  localparam int CFG_W     = metp_pkg::CFG_W;
  localparam int ZOOM_W    = metp_pkg::ZOOM_W;
  localparam int ITER_W    = metp_pkg::ITER_W;
  localparam logic [63:0] TWO_FX  = 64'd2 << FRAC_BITS;
  localparam logic [63:0] FOUR_FX = 64'd4 << FRAC_BITS;

  typedef struct packed {
    logic [SHADE_W-1:0] shade;
    logic               escaped;
  } pixel_result_t;

  class escape_scoreboard;
    logic [CFG_W-1:0]  center_re;
    logic [CFG_W-1:0]  center_im;
    logic [ZOOM_W-1:0] zoom;
    logic [ITER_W-1:0] iter_limit;
    pixel_result_t     shade_q[$];
    int                errors;
    int                checked;
    int                escapes;

    function new();
      center_re  = 48'hF800_0000_0000;  // -0.5
      center_im  = '0;
      zoom       = '0;
      iter_limit = metp_pkg::MAX_ITER_RST;
    endfunction

    function void write_reg(metp_pkg::reg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        metp_pkg::REG_CENTER_RE:  center_re = data;
        metp_pkg::REG_CENTER_IM:  center_im = data;
        metp_pkg::REG_ZOOM_LEVEL: zoom = data[ZOOM_W-1:0];
        metp_pkg::REG_MAX_ITER:   iter_limit = data[ITER_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] wrap52(logic [63:0] v);
      return {{12{v[51]}}, v[51:0]};
    endfunction

    // Product of two magnitudes, truncated to the fraction width.
    function logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[FRAC_BITS+63:FRAC_BITS];
    endfunction

    // Right shifts round toward minus infinity.
    function logic [63:0] pixel_offset(longint off, int shift);
      longint v;
      if (shift >= 0) v = off <<< shift;
      else v = off >>> (-shift);
      return wrap52(v);
    endfunction

    function pixel_result_t escape_time(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
      int            z;
      int            shift;
      int            n;
      int            q;
      logic [63:0]   cr, ci, zr, zi, ar, ai, sr, si, prod, tr;
      pixel_result_t r;
      z = $signed(zoom);
      if (z < metp_pkg::ZOOM_MIN) z = metp_pkg::ZOOM_MIN;
      if (z > metp_pkg::ZOOM_MAX) z = metp_pkg::ZOOM_MAX;
      shift = FRAC_BITS + 1 - $clog2(COLUMNS) - z;
      cr = wrap52({{16{center_re[47]}}, center_re}
                  + pixel_offset(longint'(col) - COLUMNS / 2, shift));
      ci = wrap52({{16{center_im[47]}}, center_im}
                  + pixel_offset(longint'(row) - ROWS / 2, shift));
      zr = '0;
      zi = '0;
      n = 0;
      while (n <= iter_limit) begin
        ar = zr[63] ? -zr : zr;
        ai = zi[63] ? -zi : zi;
        if (ar >= TWO_FX || ai >= TWO_FX) break;
        sr = frac_mul(ar, ar);
        si = frac_mul(ai, ai);
        if (sr + si >= FOUR_FX) break;
        prod = frac_mul(ar, ai);
        if (zr[63] != zi[63]) prod = -prod;
        tr = wrap52(sr - si + cr);
        zi = wrap52((prod << 1) + ci);
        zr = tr;
        n++;
      end
      if (n <= iter_limit && iter_limit != 0) begin
        q = (255 * n) / int'(iter_limit);
        r.shade = q[SHADE_W-1:0];
        r.escaped = 1'b1;
      end else begin
        r.shade = '0;
        r.escaped = 1'b0;
      end
      return r;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
      shade_q.push_back(escape_time(col, row));
    endfunction

    function void check_result(logic [SHADE_W-1:0] shade, logic escaped);
      pixel_result_t exp_r;
      if (shade_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending: shade %0d escaped %0b",
                 $time, shade, escaped);
        return;
      end
      exp_r = shade_q.pop_front();
      checked++;
      if (exp_r.escaped) escapes++;
      if (shade !== exp_r.shade || escaped !== exp_r.escaped) begin
        errors++;
        $display("%0t: mismatch: expected shade %0d escaped %0b, got shade %0d escaped %0b",
                 $time, exp_r.shade, exp_r.escaped, shade, escaped);
      end
    endfunction

    function int pending();
      return shade_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [PIX_W-1:0]     pixel_col;
  logic [PIX_W-1:0]     pixel_row;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SHADE_W-1:0]   shade;
  logic                 escaped;
  logic                 cfg_we;
  metp_pkg::reg_idx_e   cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  escape_scoreboard sb;
  logic             quiet = 1'b0;
  int               stall_left = 0;
  int               views = 1;

  mandelbrot_escape_time_pixel_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .pixel_col_i (pixel_col),
    .pixel_row_i (pixel_row),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .shade_o     (shade),
    .escaped_o   (escaped),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("** mandelbrot_escape_time_pixel_core: FAILED **");
    $finish;
  end

  // Result side: hold stall for a random count after each accepted result.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(shade, escaped);
      stall_left = quiet ? 0 : $urandom_range(0, 9);
    end
  end

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_col = col;
    pixel_row = row;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_pixel(col, row);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input metp_pkg::reg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_view(input logic [CFG_W-1:0] cre, input logic [CFG_W-1:0] cim,
                          input logic [ZOOM_W-1:0] zm, input logic [ITER_W-1:0] lim);
    write_reg(metp_pkg::REG_CENTER_RE, cre);
    write_reg(metp_pkg::REG_CENTER_IM, cim);
    write_reg(metp_pkg::REG_ZOOM_LEVEL, {{(CFG_W-ZOOM_W){1'b0}}, zm});
    write_reg(metp_pkg::REG_MAX_ITER, {{(CFG_W-ITER_W){1'b0}}, lim});
    cfg_we = 1'b0;
    views++;
  endtask

  // Long limits only with the center far off the set, so every point escapes at once.
  task automatic random_view();
    int                pick;
    int                zi;
    longint            v;
    logic [CFG_W-1:0]  cre, cim;
    logic [ZOOM_W-1:0] zm;
    logic [ITER_W-1:0] lim;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      cre = {$urandom_range(0, 1) ? 3'b011 : 3'b100, 13'($urandom), $urandom};
      cim = {16'($urandom), $urandom};
      zi = $urandom_range(0, 32);
      lim = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(1000, 65535));
    end else if (pick == 1) begin
      cre = {16'($urandom), $urandom};
      cim = {16'($urandom), $urandom};
      zi = $urandom_range(0, 127);
      lim = 16'($urandom_range(0, 48));
    end else begin
      v = ((longint'($urandom_range(0, 767)) - 576) <<< 36) + longint'($urandom);
      cre = v[CFG_W-1:0];
      v = ((longint'($urandom_range(0, 511)) - 256) <<< 36) + longint'($urandom);
      cim = v[CFG_W-1:0];
      zi = int'($urandom_range(0, 34)) - 2;
      lim = 16'($urandom_range(1, 48));
    end
    zm = zi[ZOOM_W-1:0];
    set_view(cre, cim, zm, lim);
  endtask

  initial begin
    int ph;
    int i;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    pixel_col = '0;
    pixel_row = '0;
    cfg_we = 1'b0;
    cfg_idx = metp_pkg::REG_CENTER_RE;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset view: corners, edges and the center, which lies deep inside the set.
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd512);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd512, 10'd0);
    drain();

    // Zero limit: one step, never reported as escaped.
    set_view('0, '0, 7'd0, 16'd0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
    drain();

    // Extreme centers with the widest in-range zoom and the largest limit.
    set_view(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 7'h7E, 16'hFFFF);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
    drain();

    // Zoom above range saturates to the top.
    set_view(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 7'h3F, 16'hFFFF);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    drain();

    // Zoom below range saturates to the bottom; escape at the limit gives full shade.
    set_view(48'h8000_0000_0000, '0, 7'h40, 16'd1);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    drain();

    set_view('0, '0, 7'd32, 16'd1);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd0);
    drain();

    for (ph = 0; ph < 10; ph++) begin
      quiet = ($urandom_range(0, 3) == 0);
      random_view();
      for (i = 0; i < 50; i++)
        send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      drain();
    end
    quiet = 1'b0;

    repeat (60) @(negedge clk);
    $display("Checked %0d pixel results (%0d escaped) over %0d view settings,",
             sb.checked, sb.escapes, views);
    $display("with random request gaps and result stalls; %0d mismatches.", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("** mandelbrot_escape_time_pixel_core: PASSED **");
    else
      $display("** mandelbrot_escape_time_pixel_core: FAILED **");
    $finish;
  end

endmodule

### mandelbrot_escape_time_pixel_core.f
rtl/metp_pkg.sv
rtl/metp_mul.sv
rtl/metp_div.sv
rtl/mandelbrot_escape_time_pixel_core.sv
tb/sv/tb.sv
